/* hdl/pli_pkg.sv */
`default_nettype none

package pli_pkg;

  // Field widths of the request and result items
  localparam int OP_W  = 2;
  localparam int POS_W = 8;
  localparam int VAL_W = 32;
  localparam int ST_W  = 2;

  // Position compares run one bit wider than the position field
  localparam int CMP_W = POS_W + 1;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_LIST   = 2'd2;

  // Result status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

endpackage

`default_nettype wire

/* hdl/pli_req_if.sv */
`default_nettype none

interface pli_req_if import pli_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         operation;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] new_value;

  modport source (output valid, output operation, output position, output new_value,
                  input ready);
  modport sink   (input valid, input operation, input position, input new_value,
                  output ready);
endinterface

`default_nettype wire

/* hdl/pli_rsp_if.sv */
`default_nettype none

interface pli_rsp_if import pli_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [ST_W-1:0]         status;
  logic signed [VAL_W-1:0] item_value;
  logic                    last;

  modport source (output valid, output status, output item_value, output last,
                  input ready);
  modport sink   (input valid, input status, input item_value, input last,
                  output ready);
endinterface

`default_nettype wire

/* hdl/pli_ram.sv */
`default_nettype none

module pli_ram import pli_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic signed [VAL_W-1:0] wdata,
  input  logic                    re,
  input  logic [AW-1:0]           raddr,
  output logic signed [VAL_W-1:0] rdata
);

  logic signed [VAL_W-1:0] mem [DEPTH];
  logic signed [VAL_W-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds its data while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* hdl/positional_list_insert_delete.sv */
// Insert: S_INS_SHIFT moves entries up from the position, then S_INS_PUT writes the value.
// Delete: S_DEL_GET takes the removed value, then S_DEL_SHIFT moves later entries down.
// List: one element per cycle while the output slot is free;
// the memory's single read port sets the one-entry-per-cycle pace.
// One request at a time; the next is taken once the last result is in the output register.
// Reset clears the count and the control state; store contents are not cleared.
`default_nettype none

module positional_list_insert_delete import pli_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  pli_req_if.sink   in_req,
  pli_rsp_if.source out_rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_INS_SHIFT = 7'b0000010,
    S_INS_PUT   = 7'b0000100,
    S_DEL_GET   = 7'b0001000,
    S_DEL_SHIFT = 7'b0010000,
    S_LIST      = 7'b0100000,
    S_RESP      = 7'b1000000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [AW-1:0]           pidx_r, pidx_nxt;
  logic [AW-1:0]           widx_r, widx_nxt;
  logic signed [VAL_W-1:0] val_r, val_nxt;
  logic [ST_W-1:0]         res_status_r, res_status_nxt;
  logic signed [VAL_W-1:0] res_value_r, res_value_nxt;

  logic                    out_valid_r;
  logic [ST_W-1:0]         out_status_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic                    out_last_r;

  logic                    push;
  logic [ST_W-1:0]         push_status;
  logic signed [VAL_W-1:0] push_value;
  logic                    push_last;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic signed [VAL_W-1:0] ram_wdata;
  logic                    ram_re;
  logic [AW-1:0]           ram_raddr;
  logic signed [VAL_W-1:0] ram_rdata;

  logic             slot_free;
  logic             in_fire;
  logic [CMP_W-1:0] pos_x, cnt_x, widx_x, pidx_x;
  logic             ins_pos_ok, del_pos_ok, store_full, last_elem;
  logic [AW-1:0]    pos_idx;

  pli_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Handshake and position checks
  assign slot_free    = !out_valid_r || out_rsp.ready;
  assign in_req.ready = rst_n && (state_r == S_IDLE);
  assign in_fire      = in_req.valid && in_req.ready;

  assign pos_x      = {1'b0, in_req.position};
  assign cnt_x      = CMP_W'(count_r);
  assign widx_x     = CMP_W'(widx_r);
  assign pidx_x     = CMP_W'(pidx_r);
  assign ins_pos_ok = (pos_x != '0) && (pos_x <= cnt_x + CMP_W'(1));
  assign del_pos_ok = (pos_x != '0) && (pos_x <= cnt_x);
  assign store_full = (count_r == CW'(DEPTH));
  assign pos_idx    = AW'(pos_x - CMP_W'(1));
  assign last_elem  = (widx_x + CMP_W'(1) == cnt_x);

  // Sequencer: read ahead, write back one entry per cycle
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pidx_nxt       = pidx_r;
    widx_nxt       = widx_r;
    val_nxt        = val_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    ram_we         = 1'b0;
    ram_waddr      = widx_r;
    ram_wdata      = ram_rdata;
    ram_re         = 1'b0;
    ram_raddr      = '0;
    push           = 1'b0;
    push_status    = ST_OK;
    push_value     = ram_rdata;
    push_last      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          val_nxt = in_req.new_value;
          unique case (in_req.operation)
            OP_INSERT: begin
              if (!ins_pos_ok) begin
                res_status_nxt = ST_RANGE;
                res_value_nxt  = '0;
                state_nxt      = S_RESP;
              end else if (store_full) begin
                res_status_nxt = ST_FULL;
                res_value_nxt  = '0;
                state_nxt      = S_RESP;
              end else begin
                pidx_nxt = pos_idx;
                if (cnt_x >= pos_x) begin
                  ram_re    = 1'b1;
                  ram_raddr = AW'(cnt_x - CMP_W'(1));
                  widx_nxt  = AW'(cnt_x);
                  state_nxt = S_INS_SHIFT;
                end else begin
                  state_nxt = S_INS_PUT;
                end
              end
            end
            OP_DELETE: begin
              if (!del_pos_ok) begin
                res_status_nxt = ST_RANGE;
                res_value_nxt  = '0;
                state_nxt      = S_RESP;
              end else begin
                pidx_nxt  = pos_idx;
                ram_re    = 1'b1;
                ram_raddr = pos_idx;
                state_nxt = S_DEL_GET;
              end
            end
            OP_LIST: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
                res_value_nxt  = '0;
                state_nxt      = S_RESP;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                widx_nxt  = '0;
                state_nxt = S_LIST;
              end
            end
            default: begin
              // unused code: drop the request
            end
          endcase
        end
      end

      S_INS_SHIFT: begin
        // move entry widx-1 up to widx
        ram_we    = 1'b1;
        ram_waddr = widx_r;
        ram_wdata = ram_rdata;
        if (widx_x == pidx_x + CMP_W'(1)) begin
          state_nxt = S_INS_PUT;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(widx_x - CMP_W'(2));
          widx_nxt  = AW'(widx_x - CMP_W'(1));
        end
      end

      S_INS_PUT: begin
        ram_we         = 1'b1;
        ram_waddr      = pidx_r;
        ram_wdata      = val_r;
        count_nxt      = count_r + CW'(1);
        res_status_nxt = ST_OK;
        res_value_nxt  = val_r;
        state_nxt      = S_RESP;
      end

      S_DEL_GET: begin
        // capture the removed value, then close the gap
        res_status_nxt = ST_OK;
        res_value_nxt  = ram_rdata;
        if (pidx_x + CMP_W'(1) < cnt_x) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(pidx_x + CMP_W'(1));
          widx_nxt  = pidx_r;
          state_nxt = S_DEL_SHIFT;
        end else begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_RESP;
        end
      end

      S_DEL_SHIFT: begin
        // move entry widx+1 down to widx
        ram_we    = 1'b1;
        ram_waddr = widx_r;
        ram_wdata = ram_rdata;
        if (widx_x + CMP_W'(2) == cnt_x) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_RESP;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(widx_x + CMP_W'(2));
          widx_nxt  = AW'(widx_x + CMP_W'(1));
        end
      end

      S_LIST: begin
        // emit one element per free output slot, read the next one alongside
        if (slot_free) begin
          push        = 1'b1;
          push_status = ST_OK;
          push_value  = ram_rdata;
          push_last   = last_elem;
          if (last_elem) begin
            state_nxt = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = AW'(widx_x + CMP_W'(1));
            widx_nxt  = AW'(widx_x + CMP_W'(1));
          end
        end
      end

      S_RESP: begin
        if (slot_free) begin
          push        = 1'b1;
          push_status = res_status_r;
          push_value  = res_value_r;
          push_last   = 1'b1;
          state_nxt   = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (push) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working registers and output payload
  always_ff @(posedge clk) begin
    pidx_r       <= pidx_nxt;
    widx_r       <= widx_nxt;
    val_r        <= val_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    if (push) begin
      out_status_r <= push_status;
      out_value_r  <= push_value;
      out_last_r   <= push_last;
    end
  end

  assign out_rsp.valid      = out_valid_r;
  assign out_rsp.status     = out_status_r;
  assign out_rsp.item_value = out_value_r;
  assign out_rsp.last       = out_last_r;

endmodule

`default_nettype wire
